/* src/gpsc_pkg.sv */
// Package: alphabets, state type and substitution function for the grouped substitution cipher.
package gpsc_pkg;

  localparam int unsigned AlphaLen = 65;
  localparam int unsigned AlphaW   = 8 * AlphaLen;

  localparam logic [AlphaW-1:0] ALPHA_A =
    "QW/47SDv935=ERIhjklzxc0XCVTYUBNMqwerbnm1pasdotyuiOPA82+fgFGHJKLZ6";
  localparam logic [AlphaW-1:0] ALPHA_C =
    "!$%wTG+)qazBsMxedcW(YHmi@#kolpPOhnIKUJuQAZ=VEDC-SNvt^&LR*gbyXrfjF";
  localparam logic [AlphaW-1:0] ALPHA_B =
    "X1piOxCsdKLZ62l7Q93tyumc0SVTY5=aDv+fgFGHJIhjkwerbERNMqoPA84nzUBW/";

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       miss;
    logic [7:0] code;
  } sub_res_t;

  // character k of a string sits k bytes down from the top
  function automatic logic [7:0] alpha_char(input logic [AlphaW-1:0] str, input int unsigned k);
    alpha_char = str[8*(AlphaLen-1-k) +: 8];
  endfunction

  // first match wins: scan from the top index down so lower indices overwrite
  function automatic sub_res_t substitute(input logic [7:0]        sym,
                                          input logic [AlphaW-1:0] src,
                                          input logic [AlphaW-1:0] dst);
    sub_res_t r;
    r.miss = 1'b1;
    r.code = 8'h00;
    for (int k = AlphaLen - 1; k >= 0; k--) begin
      if (alpha_char(src, k) == sym) begin
        r.miss = 1'b0;
        r.code = alpha_char(dst, k);
      end
    end
    return r;
  endfunction

endpackage

/* src/grouped_position_substitution_cipher.sv */
// A byte that closes a group or ends the message starts read-out; each result then passes the
// registered buffer read and the output register. Results leave at one per cycle from the group
// buffer RAM (one read port) while the output is not stalled. Input is held off while the buffer
// is read out.
// Reset clears fill count, state, valids and direction (encode); the buffer RAM is not cleared.
module grouped_position_substitution_cipher #(
  parameter int unsigned GROUP_SIZE = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config: direction, 0 encode, 1 decode
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol_in
  input  logic       s_axis_tlast_i,   // is_final
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] symbol_out
  output logic [1:0] m_axis_tuser_o,   // [0] not_in_alphabet, [1] message_end
  output logic       m_axis_tlast_o    // run_end
);

  localparam int unsigned IW   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int unsigned CW   = $clog2(GROUP_SIZE + 1);
  localparam int unsigned HALF = GROUP_SIZE / 2;

  gpsc_pkg::state_e state_q, state_d;

  logic          dir_q;
  logic [IW-1:0] fill_q, fill_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] left_q, left_d;
  logic          rev_q, rev_d;
  logic          fin_q, fin_d;

  logic [7:0]    mem_q [GROUP_SIZE];
  logic [7:0]    rd_data_q;
  logic          rd_vld_q;
  logic          rd_first_q;
  logic          rd_last_q;
  logic          rd_fin_q;

  logic          m_valid_q;
  logic [7:0]    m_sym_q;
  logic          m_miss_q;
  logic          m_last_q;
  logic          m_end_q;

  logic          in_xfer;
  logic          grp_full;
  logic          out_free;
  logic          advance;
  logic          rd_en;
  logic          is_last_rd;
  logic          first_map;

  gpsc_pkg::sub_res_t sub_res;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = s_axis_tvalid_i && s_axis_tready_o;
  assign grp_full    = (CW'(fill_q) + CW'(1)) == CW'(GROUP_SIZE);
  assign out_free    = !m_valid_q || m_axis_tready_i;
  assign advance     = rd_vld_q && out_free;
  assign is_last_rd  = left_q == CW'(1);
  assign first_map   = rev_q || (CW'(ptr_q) < CW'(HALF));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gpsc_pkg::ST_FILL: begin
        if (in_xfer && (grp_full || s_axis_tlast_i)) state_d = gpsc_pkg::ST_EMIT;
      end
      gpsc_pkg::ST_EMIT: begin
        if (rd_en && is_last_rd) state_d = gpsc_pkg::ST_FILL;
      end
      default: state_d = gpsc_pkg::ST_FILL;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    unique case (state_q)
      gpsc_pkg::ST_FILL: s_axis_tready_o = 1'b1;
      gpsc_pkg::ST_EMIT: rd_en = !rd_vld_q || advance;
      default: ;
    endcase
  end

  // fill count and read-out sequencing
  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    left_d = left_q;
    rev_d  = rev_q;
    fin_d  = fin_q;
    if (in_xfer) begin
      fin_d = s_axis_tlast_i;
      if (grp_full) begin
        fill_d = '0;
        ptr_d  = '0;
        left_d = CW'(GROUP_SIZE);
        rev_d  = 1'b0;
      end else if (s_axis_tlast_i) begin
        fill_d = '0;
        ptr_d  = fill_q;
        left_d = CW'(fill_q) + CW'(1);
        rev_d  = 1'b1;
      end else begin
        fill_d = fill_q + IW'(1);
      end
    end else if (rd_en) begin
      left_d = left_q - CW'(1);
      ptr_d  = rev_q ? ptr_q - IW'(1) : ptr_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gpsc_pkg::ST_FILL;
      dir_q     <= 1'b0;
      fill_q    <= '0;
      ptr_q     <= '0;
      left_q    <= '0;
      rev_q     <= 1'b0;
      fin_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      left_q  <= left_d;
      rev_q   <= rev_d;
      fin_q   <= fin_d;
      if (cfg_valid_i) dir_q <= cfg_data_i;
      if (rd_en) begin
        rd_vld_q <= 1'b1;
      end else if (advance) begin
        rd_vld_q <= 1'b0;
      end
      if (advance) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // group buffer RAM, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (in_xfer) mem_q[fill_q] <= s_axis_tdata_i;
    if (rd_en) begin
      rd_data_q  <= mem_q[ptr_q];
      rd_first_q <= first_map;
      rd_last_q  <= is_last_rd;
      rd_fin_q   <= fin_q && is_last_rd;
    end
  end

  always_comb begin
    if (rd_first_q) begin
      sub_res = dir_q ? gpsc_pkg::substitute(rd_data_q, gpsc_pkg::ALPHA_C, gpsc_pkg::ALPHA_A)
                      : gpsc_pkg::substitute(rd_data_q, gpsc_pkg::ALPHA_A, gpsc_pkg::ALPHA_C);
    end else begin
      sub_res = dir_q ? gpsc_pkg::substitute(rd_data_q, gpsc_pkg::ALPHA_C, gpsc_pkg::ALPHA_B)
                      : gpsc_pkg::substitute(rd_data_q, gpsc_pkg::ALPHA_B, gpsc_pkg::ALPHA_C);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_sym_q  <= sub_res.code;
      m_miss_q <= sub_res.miss;
      m_last_q <= rd_last_q;
      m_end_q  <= rd_fin_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_sym_q;
  assign m_axis_tuser_o  = {m_end_q, m_miss_q};
  assign m_axis_tlast_o  = m_last_q;

  // buffer is never written and read in the same cycle
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && rd_en))
    else $error("group buffer written during read-out");

  // message end only ever on a run end
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_end_q) |-> m_last_q)
    else $error("message_end without run_end");

  // a stalled read keeps its data
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && !out_free) |=> (rd_vld_q && $stable(rd_data_q)))
    else $error("read stage lost data under back-pressure");

  // read-out count stays within a group
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= CW'(GROUP_SIZE))
    else $error("read-out count beyond group size");

endmodule

/* tb/sv/tb.sv */
// Testbench for grouped_position_substitution_cipher: directed table, random messages, predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GROUP       = 16;
  localparam int unsigned CHARSET_LEN = 65;
  localparam int unsigned CHARSET_W   = 8 * CHARSET_LEN;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 36;

  localparam logic [CHARSET_W-1:0] CHARSET_A =
    "QW/47SDv935=ERIhjklzxc0XCVTYUBNMqwerbnm1pasdotyuiOPA82+fgFGHJKLZ6";
  localparam logic [CHARSET_W-1:0] CHARSET_C =
    "!$%wTG+)qazBsMxedcW(YHmi@#kolpPOhnIKUJuQAZ=VEDC-SNvt^&LR*gbyXrfjF";
  localparam logic [CHARSET_W-1:0] CHARSET_B =
    "X1piOxCsdKLZ62l7Q93tyumc0SVTY5=aDv+fgFGHJIhjkwerbERNMqoPA84nzUBW/";

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef enum logic {
    ROW_BYTE,
    ROW_DIR
  } row_kind_e;

  typedef struct packed {
    logic [7:0] sym;
    logic       miss;
    logic       run_end;
    logic       msg_end;
  } cipher_res_t;

  typedef struct packed {
    row_kind_e  kind;
    dir_e       dir;
    logic [7:0] sym;
    logic       fin;
    logic       typed;
    logic [7:0] exp_sym;
    logic       exp_miss;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 25;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{ROW_BYTE, DIR_ENCODE, "Q",   1'b1, 1'b1, "!",   1'b0},
    '{ROW_BYTE, DIR_ENCODE, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
    '{ROW_BYTE, DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},
    '{ROW_BYTE, DIR_ENCODE, "6",   1'b1, 1'b1, "F",   1'b0},
    // full group closing on the final byte
    '{ROW_BYTE, DIR_ENCODE, "Q",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "W",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "/",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "4",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "7",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "S",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "!",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "v",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "X",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "1",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "p",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "Q",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "W",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "/",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, 8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
    // tail with direction flipped while bytes are buffered
    '{ROW_BYTE, DIR_ENCODE, "a",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "z",   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_DIR,  DIR_DECODE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "A",   1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, DIR_ENCODE, "!",   1'b1, 1'b1, "Q",   1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_dir;
  logic       s_valid;
  logic       s_ready;
  logic [7:0] s_data;
  logic       s_last;
  logic       m_valid;
  logic       m_ready;
  logic [7:0] m_data;
  logic [1:0] m_user;
  logic       m_last;

  dir_e        cipher_dir;
  logic [7:0]  group_bytes [GROUP];
  int unsigned group_fill;
  cipher_res_t expected_symbols [$];

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  int unsigned results_checked;
  int unsigned dir_writes;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  grouped_position_substitution_cipher #(
    .GROUP_SIZE(GROUP)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_dir),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [7:0] symbol_in
    .s_axis_tlast_i  (s_last),   // is_final
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // [7:0] symbol_out
    .m_axis_tuser_o  (m_user),   // [0] not_in_alphabet, [1] message_end
    .m_axis_tlast_o  (m_last)    // run_end
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] charset_at(input logic [CHARSET_W-1:0] set, input int k);
    return set[8*(CHARSET_LEN-1-k) +: 8];
  endfunction

  function automatic cipher_res_t substitute_sym(input logic [7:0] sym, input logic first_half);
    logic [CHARSET_W-1:0] src;
    logic [CHARSET_W-1:0] dst;
    cipher_res_t          r;
    if (cipher_dir == DIR_ENCODE) begin
      src = first_half ? CHARSET_A : CHARSET_B;
      dst = CHARSET_C;
    end else begin
      src = CHARSET_C;
      dst = first_half ? CHARSET_A : CHARSET_B;
    end
    r      = '0;
    r.miss = 1'b1;
    for (int k = 0; k < CHARSET_LEN; k++) begin
      if (r.miss && charset_at(src, k) == sym) begin
        r.miss = 1'b0;
        r.sym  = charset_at(dst, k);
      end
    end
    return r;
  endfunction

  // buffer one byte; queue the group or the reversed tail when it closes
  task automatic predict_cipher_bytes(input logic [7:0] sym, input logic fin);
    cipher_res_t r;
    if (group_fill >= GROUP) group_fill = 0;
    group_bytes[group_fill] = sym;
    group_fill++;
    if (group_fill == GROUP) begin
      for (int p = 0; p < GROUP; p++) begin
        r         = substitute_sym(group_bytes[p], p < GROUP / 2);
        r.run_end = (p == GROUP - 1);
        r.msg_end = (p == GROUP - 1) && fin;
        expected_symbols.push_back(r);
      end
      group_fill = 0;
    end else if (fin) begin
      for (int p = group_fill - 1; p >= 0; p--) begin
        r         = substitute_sym(group_bytes[p], 1'b1);
        r.run_end = (p == 0);
        r.msg_end = (p == 0);
        expected_symbols.push_back(r);
      end
      group_fill = 0;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_byte(input logic [7:0] sym, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = sym;
    s_last  = fin;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    predict_cipher_bytes(sym, fin);
    bytes_sent++;
    if (fin) messages_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_valid = 1'b0;
    while (expected_symbols.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_dir(input dir_e d);
    cfg_valid = 1'b1;
    cfg_dir   = d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cipher_dir = d;
    dir_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(9))
      0, 1, 2: return charset_at(CHARSET_A, $urandom_range(CHARSET_LEN - 1));
      3, 4:    return charset_at(CHARSET_B, $urandom_range(CHARSET_LEN - 1));
      5, 6, 7: return charset_at(CHARSET_C, $urandom_range(CHARSET_LEN - 1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    m_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cipher_res_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_symbols.size() == 0) begin
        $error("symbol_out: expected nothing, got %h", m_data);
        errors++;
      end else begin
        want = expected_symbols.pop_front();
        check_field("symbol_out", want.sym, m_data);
        check_field("not_in_alphabet", 8'(want.miss), 8'(m_user[0]));
        check_field("run_end", 8'(want.run_end), 8'(m_last));
        check_field("message_end", 8'(want.msg_end), 8'(m_user[1]));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    int        len;
    int        flip_at;
    int        sent;
    rst_ni          = 1'b0;
    cfg_valid       = 1'b0;
    cfg_dir         = DIR_ENCODE;
    s_valid         = 1'b0;
    s_data          = 8'h00;
    s_last          = 1'b0;
    cipher_dir      = DIR_ENCODE;
    group_fill      = 0;
    bytes_sent      = 0;
    messages_sent   = 0;
    dir_writes      = 0;
    send_idle_pct   = 33;
    recv_idle_pct   = 58;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == ROW_DIR) begin
        wait_drained();
        write_dir(row.dir);
      end else begin
        push_byte(row.sym, row.fin);
        // single-result rows with the answer written in the table
        if (row.typed) begin
          void'(expected_symbols.pop_back());
          expected_symbols.push_back('{row.exp_sym, row.exp_miss, 1'b1, 1'b1});
        end
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 33; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wait_drained();
      case (phase)
        0:       write_dir(DIR_ENCODE);
        1:       write_dir(DIR_DECODE);
        default: write_dir(dir_e'($urandom_range(1)));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(5))
          0:       len = GROUP;
          1:       len = 2 * GROUP;
          default: len = $urandom_range(1, 40);
        endcase
        if (len > int'(PHASE_ITEMS) - sent) len = int'(PHASE_ITEMS) - sent;
        flip_at = ($urandom_range(5) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == flip_at) begin
            wait_drained();
            write_dir(dir_e'($urandom_range(1)));
          end
          push_byte(rand_symbol(), i == len - 1);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d bytes in %0d messages, checked %0d results.",
             bytes_sent, messages_sent, results_checked);
    $display("Direction written %0d times, encode and decode, incl. mid-group changes.",
             dir_writes);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
